// ===== rtl/ltgq_pkg.sv =====
// shared types and status codes for the lock table
`default_nettype none
package ltgq_pkg;
    localparam int MODE_BITS = 3;
    localparam int STATUS_BITS = 3;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GRANTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_DUP_OWNED   = 3'd2,
        ST_DUP_PENDING = 3'd3,
        ST_REL_OWNED   = 3'd4,
        ST_REL_PENDING = 3'd5,
        ST_NOT_FOUND   = 3'd6,
        ST_NO_ROOM     = 3'd7
    } status_t;

    typedef enum logic {
        OP_LOCK    = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;
endpackage
`default_nettype wire

// ===== rtl/ltgq_fifo.sv =====
// short command queue between the front end and the lock engine
`default_nettype none
module ltgq_fifo
    import ltgq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ltgq_engine.sv =====
// lock engine: slot lookup, list scans, grant cascade and result register
`default_nettype none
module ltgq_engine
    import ltgq_pkg::*;
#(
    parameter int RESOURCE_SLOTS = 16,
    parameter int OWNED_DEPTH    = 8,
    parameter int PENDING_DEPTH  = 8,
    parameter int NUM_MODES      = 6,
    parameter int TXN_BITS       = 16,
    parameter int KEY_BITS       = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [NUM_MODES*NUM_MODES-1:0] compat,
    input  wire logic                         cmd_valid,
    output logic                              cmd_ready,
    input  wire logic                         cmd_op,
    input  wire logic [TXN_BITS-1:0]          cmd_txn,
    input  wire logic [KEY_BITS-1:0]          cmd_key,
    input  wire logic [MODE_BITS-1:0]         cmd_mode,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [STATUS_BITS-1:0]            res_status
);
    localparam int SW = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
    localparam int OCW = $clog2(OWNED_DEPTH + 1);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int SCW = $clog2(RESOURCE_SLOTS + 1);
    localparam int OE = RESOURCE_SLOTS * OWNED_DEPTH;
    localparam int PE = RESOURCE_SLOTS * PENDING_DEPTH;
    localparam int OAW = (OE > 1) ? $clog2(OE) : 1;
    localparam int PAW = (PE > 1) ? $clog2(PE) : 1;
    localparam int EW = TXN_BITS + MODE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_OSCAN, S_PSCAN, S_DECIDE, S_OSHIFT, S_PSHIFT,
        S_GHEAD, S_GCHK, S_GMOVE, S_DONE, S_OUT
    } state_t;

    state_t state_reg;

    logic [KEY_BITS-1:0]  slot_key_mem [RESOURCE_SLOTS];
    logic                 slot_valid_reg [RESOURCE_SLOTS];
    logic [OCW-1:0]       ocnt_reg [RESOURCE_SLOTS];
    logic [PCW-1:0]       pcnt_reg [RESOURCE_SLOTS];
    logic [EW-1:0]        own_mem [OE];
    logic [EW-1:0]        pend_mem [PE];

    logic                 op_reg;
    logic [TXN_BITS-1:0]  txn_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [MODE_BITS-1:0] mode_reg;
    logic [SCW-1:0]       sidx_reg;
    logic [SW-1:0]        slot_reg;
    logic                 found_reg, free_seen_reg;
    logic [SW-1:0]        free_reg;
    logic [OCW-1:0]       oi_reg, ocnt_cur;
    logic [PCW-1:0]       pi_reg, pcnt_cur;
    logic                 rd_pend_reg;
    logic [EW-1:0]        rdata_reg;
    logic                 fits_reg, ohit_reg, phit_reg;
    logic [OCW-1:0]       opos_reg;
    logic [PCW-1:0]       ppos_reg;
    logic [EW-1:0]        head_reg;
    logic [STATUS_BITS-1:0] st_reg;
    logic                 wait_reg;

    logic [OAW-1:0] own_ra, own_wa;
    logic [PAW-1:0] pend_ra, pend_wa;
    logic           own_we, pend_we;
    logic [EW-1:0]  own_wd, pend_wd, own_rd, pend_rd;
    logic [MODE_BITS-1:0] rmode, cmode;
    logic           compat_ok;

    assign ocnt_cur  = ocnt_reg[slot_reg];
    assign pcnt_cur  = pcnt_reg[slot_reg];
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_status = st_reg;
    assign rmode = rdata_reg[MODE_BITS-1:0];

    // compat of the mode under test (own request or pending head) vs an owner
    assign cmode = rd_pend_reg ? head_reg[MODE_BITS-1:0] : mode_reg;
    always_comb
    begin
        compat_ok = 1'b0;
        if (int'(cmode) < NUM_MODES && int'(rmode) < NUM_MODES)
        begin
            compat_ok = compat[int'(cmode) * NUM_MODES + int'(rmode)];
        end
    end

    function automatic logic [OAW-1:0] oaddr(input logic [SW-1:0] s, input logic [OCW-1:0] i);
        oaddr = OAW'(int'(s) * OWNED_DEPTH + int'(i));
    endfunction
    function automatic logic [PAW-1:0] paddr(input logic [SW-1:0] s, input logic [PCW-1:0] i);
        paddr = PAW'(int'(s) * PENDING_DEPTH + int'(i));
    endfunction

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_wa] <= own_wd;
        end
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        own_rd  <= own_mem[own_ra];
        pend_rd <= pend_mem[pend_ra];
    end

    // memory address and write control
    always_comb
    begin
        own_ra  = oaddr(slot_reg, oi_reg);
        pend_ra = paddr(slot_reg, pi_reg);
        own_we  = 1'b0;
        pend_we = 1'b0;
        own_wa  = oaddr(slot_reg, oi_reg);
        pend_wa = paddr(slot_reg, pi_reg);
        own_wd  = {txn_reg, mode_reg};
        pend_wd = {txn_reg, mode_reg};
        unique case (state_reg)
            S_OSHIFT:
            begin
                // copy entry oi into oi-1 using the data read last cycle
                own_we = wait_reg && (oi_reg < ocnt_cur);
                own_wa = oaddr(slot_reg, oi_reg - 1'b1);
                own_wd = own_rd;
            end
            S_PSHIFT:
            begin
                pend_we = wait_reg && (pi_reg < pcnt_cur);
                pend_wa = paddr(slot_reg, pi_reg - 1'b1);
                pend_wd = pend_rd;
            end
            S_DECIDE:
            begin
                own_wa = oaddr(slot_reg, ocnt_cur);
                pend_wa = paddr(slot_reg, pcnt_cur);
                if (!ohit_reg && !phit_reg && op_reg == OP_LOCK && found_reg)
                begin
                    if (pcnt_cur == '0 && fits_reg)
                    begin
                        own_we = (int'(ocnt_cur) < OWNED_DEPTH);
                    end
                    else
                    begin
                        pend_we = (int'(pcnt_cur) < PENDING_DEPTH);
                    end
                end
            end
            S_GMOVE:
            begin
                own_we = 1'b1;
                own_wa = oaddr(slot_reg, ocnt_cur);
                own_wd = head_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            txn_reg  <= cmd_txn;
            key_reg  <= cmd_key;
            mode_reg <= cmd_mode;
            op_reg   <= cmd_op;
        end
        if (state_reg == S_DECIDE && !found_reg && op_reg == OP_LOCK && free_seen_reg)
        begin
            slot_key_mem[free_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int s = 0; s < RESOURCE_SLOTS; s++)
            begin
                slot_valid_reg[s] <= 1'b0;
                ocnt_reg[s] <= '0;
                pcnt_reg[s] <= '0;
            end
            sidx_reg <= '0;
            slot_reg <= '0;
            found_reg <= 1'b0;
            free_seen_reg <= 1'b0;
            free_reg <= '0;
            oi_reg <= '0;
            pi_reg <= '0;
            rd_pend_reg <= 1'b0;
            rdata_reg <= '0;
            fits_reg <= 1'b0;
            ohit_reg <= 1'b0;
            phit_reg <= 1'b0;
            opos_reg <= '0;
            ppos_reg <= '0;
            head_reg <= '0;
            st_reg <= ST_NOT_FOUND;
            wait_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_FIND;
                        sidx_reg <= '0;
                        found_reg <= 1'b0;
                        free_seen_reg <= 1'b0;
                    end
                end
                // one slot a cycle: match the key, note the lowest free slot
                S_FIND:
                begin
                    if (slot_valid_reg[sidx_reg[SW-1:0]] &&
                        slot_key_mem[sidx_reg[SW-1:0]] == key_reg)
                    begin
                        found_reg <= 1'b1;
                        slot_reg <= sidx_reg[SW-1:0];
                    end
                    if (!slot_valid_reg[sidx_reg[SW-1:0]] && !free_seen_reg)
                    begin
                        free_seen_reg <= 1'b1;
                        free_reg <= sidx_reg[SW-1:0];
                    end
                    if (int'(sidx_reg) == RESOURCE_SLOTS - 1 ||
                        (slot_valid_reg[sidx_reg[SW-1:0]] &&
                         slot_key_mem[sidx_reg[SW-1:0]] == key_reg))
                    begin
                        state_reg <= S_OSCAN;
                        oi_reg <= '0;
                        pi_reg <= '0;
                        wait_reg <= 1'b0;
                        fits_reg <= 1'b1;
                        ohit_reg <= 1'b0;
                        phit_reg <= 1'b0;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                end
                // scan owned list: a read issues, its data arrives in the next cycle
                S_OSCAN:
                begin
                    if (!found_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else if (!wait_reg)
                    begin
                        if (oi_reg >= ocnt_cur)
                        begin
                            state_reg <= S_PSCAN;
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        rdata_reg <= own_rd;
                        state_reg <= S_GCHK;
                    end
                end
                S_GCHK:
                begin
                    if (!rd_pend_reg)
                    begin
                        // evaluate one owned entry for the scan
                        if (!compat_ok)
                        begin
                            fits_reg <= 1'b0;
                        end
                        if (op_reg == OP_LOCK)
                        begin
                            if (rdata_reg == {txn_reg, mode_reg})
                            begin
                                ohit_reg <= 1'b1;
                            end
                        end
                        else if (rdata_reg[EW-1:MODE_BITS] == txn_reg)
                        begin
                            ohit_reg <= 1'b1;
                            opos_reg <= oi_reg;
                        end
                        if ((op_reg == OP_LOCK && rdata_reg == {txn_reg, mode_reg}) ||
                            (op_reg == OP_RELEASE && rdata_reg[EW-1:MODE_BITS] == txn_reg))
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            oi_reg <= oi_reg + 1'b1;
                            state_reg <= S_OSCAN;
                        end
                    end
                    else
                    begin
                        // cascade: head vs one owner
                        if (!compat_ok)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            oi_reg <= oi_reg + 1'b1;
                            state_reg <= S_GHEAD;
                        end
                    end
                end
                S_PSCAN:
                begin
                    if (!wait_reg)
                    begin
                        if (pi_reg >= pcnt_cur)
                        begin
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        if ((op_reg == OP_LOCK && pend_rd == {txn_reg, mode_reg}) ||
                            (op_reg == OP_RELEASE && pend_rd[EW-1:MODE_BITS] == txn_reg))
                        begin
                            phit_reg <= 1'b1;
                            ppos_reg <= pi_reg;
                            state_reg <= S_DECIDE;
                        end
                        else
                        begin
                            pi_reg <= pi_reg + 1'b1;
                        end
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    if (op_reg == OP_LOCK)
                    begin
                        if (!found_reg)
                        begin
                            if (!free_seen_reg)
                            begin
                                st_reg <= ST_NO_ROOM;
                            end
                            else
                            begin
                                // new slot, both lists empty: grant if room
                                slot_valid_reg[free_reg] <= 1'b1;
                                slot_reg <= free_reg;
                                found_reg <= 1'b1;
                                ocnt_reg[free_reg] <= '0;
                                pcnt_reg[free_reg] <= '0;
                                st_reg <= ST_GRANTED;
                                oi_reg <= '0;
                                state_reg <= S_DECIDE;
                            end
                        end
                        else if (ohit_reg)
                        begin
                            st_reg <= ST_DUP_OWNED;
                        end
                        else if (phit_reg)
                        begin
                            st_reg <= ST_DUP_PENDING;
                        end
                        else if (pcnt_cur == '0 && fits_reg)
                        begin
                            if (int'(ocnt_cur) >= OWNED_DEPTH)
                            begin
                                st_reg <= ST_NO_ROOM;
                            end
                            else
                            begin
                                ocnt_reg[slot_reg] <= ocnt_cur + 1'b1;
                                st_reg <= ST_GRANTED;
                            end
                        end
                        else if (int'(pcnt_cur) >= PENDING_DEPTH)
                        begin
                            st_reg <= ST_NO_ROOM;
                        end
                        else
                        begin
                            pcnt_reg[slot_reg] <= pcnt_cur + 1'b1;
                            st_reg <= ST_QUEUED;
                        end
                    end
                    else if (!found_reg)
                    begin
                        st_reg <= ST_NOT_FOUND;
                    end
                    else if (ohit_reg)
                    begin
                        st_reg <= ST_REL_OWNED;
                        oi_reg <= opos_reg + 1'b1;
                        wait_reg <= 1'b0;
                        state_reg <= S_OSHIFT;
                    end
                    else if (phit_reg)
                    begin
                        st_reg <= ST_REL_PENDING;
                        pi_reg <= ppos_reg + 1'b1;
                        wait_reg <= 1'b0;
                        state_reg <= S_PSHIFT;
                    end
                    else
                    begin
                        st_reg <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                end
                // close the gap: read entry i, then write it at i-1
                S_OSHIFT:
                begin
                    if (!wait_reg)
                    begin
                        if (oi_reg >= ocnt_cur)
                        begin
                            ocnt_reg[slot_reg] <= ocnt_cur - 1'b1;
                            pi_reg <= '0;
                            state_reg <= S_GHEAD;
                            rd_pend_reg <= 1'b0;
                            wait_reg <= 1'b0;
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        oi_reg <= oi_reg + 1'b1;
                    end
                end
                S_PSHIFT:
                begin
                    if (!wait_reg)
                    begin
                        if (pi_reg >= pcnt_cur)
                        begin
                            pcnt_reg[slot_reg] <= pcnt_cur - 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        pi_reg <= pi_reg + 1'b1;
                        if (rd_pend_reg && pi_reg + 1'b1 >= pcnt_cur)
                        begin
                            // cascade shift finished: move the head into owners
                            pcnt_reg[slot_reg] <= pcnt_cur - 1'b1;
                            state_reg <= S_GMOVE;
                        end
                    end
                end
                // grant cascade: fetch pending head, then check every owner
                S_GHEAD:
                begin
                    if (!rd_pend_reg)
                    begin
                        if (pcnt_cur == '0 || int'(ocnt_cur) >= OWNED_DEPTH)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (!wait_reg)
                        begin
                            pi_reg <= '0;
                            wait_reg <= 1'b1;
                        end
                        else
                        begin
                            wait_reg <= 1'b0;
                            head_reg <= pend_rd;
                            rd_pend_reg <= 1'b1;
                            oi_reg <= '0;
                        end
                    end
                    else if (oi_reg >= ocnt_cur)
                    begin
                        // fits every owner: shift pending list down by one
                        if (pcnt_cur == PCW'(1))
                        begin
                            pcnt_reg[slot_reg] <= '0;
                            state_reg <= S_GMOVE;
                        end
                        else
                        begin
                            pi_reg <= PCW'(1);
                            wait_reg <= 1'b0;
                            state_reg <= S_PSHIFT;
                        end
                    end
                    else if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                        rdata_reg <= own_rd;
                        state_reg <= S_GCHK;
                    end
                end
                S_GMOVE:
                begin
                    ocnt_reg[slot_reg] <= ocnt_cur + 1'b1;
                    // next head fetch reads entry 0
                    pi_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    wait_reg <= 1'b0;
                    state_reg <= S_GHEAD;
                end
                S_DONE:
                begin
                    if (ocnt_cur == '0 && pcnt_cur == '0)
                    begin
                        slot_valid_reg[slot_reg] <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ltgq_front.sv =====
// front end: accepts words, holds config, passes words through to the queue
`default_nettype none
module ltgq_front
    import ltgq_pkg::*;
#(
    parameter int NUM_MODES = 6,
    parameter int TXN_BITS  = 16,
    parameter int KEY_BITS  = 32,
    parameter int CMD_W     = 1 + TXN_BITS + KEY_BITS + MODE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [NUM_MODES*NUM_MODES-1:0] cfg_wdata,
    output logic [NUM_MODES*NUM_MODES-1:0]      compat,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [CMD_W-1:0]               in_data,
    output logic                                q_valid,
    input  wire logic                           q_ready,
    output logic [CMD_W-1:0]                    q_data
);
    logic [NUM_MODES*NUM_MODES-1:0] compat_reg;

    assign compat   = compat_reg;
    assign q_valid  = in_valid;
    assign in_ready = q_ready;
    // modes beyond the table are stored as given; engine treats them as incompatible
    assign q_data   = in_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compat_reg <= '0;
        end
        else if (cfg_we)
        begin
            compat_reg <= cfg_wdata;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lock_table_grant_queue.sv =====
// top level of the lock table with grant queue
// Lock table: each word is a lock or release request against a resource key.
// A request goes through a two-entry queue to the engine, which scans slots
// one per cycle, then the owned list and the pending list entry by entry,
// and on an owned release shifts the lists down and grants pending heads in
// order. The list memories have one read and one write port with registered
// read data.
`default_nettype none
module lock_table_grant_queue
    import ltgq_pkg::*;
#(
    parameter int RESOURCE_SLOTS = 16,
    parameter int OWNED_DEPTH    = 8,
    parameter int PENDING_DEPTH  = 8,
    parameter int NUM_MODES      = 6,
    parameter int TXN_BITS       = 16,
    parameter int KEY_BITS       = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [NUM_MODES*NUM_MODES-1:0] cfg_wdata,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // opcode, txn, key, mode, zero pad
    input  wire logic [((1+TXN_BITS+KEY_BITS+MODE_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // status, zero pad
    output logic [7:0] m_tdata
);
    localparam int CMD_W = 1 + TXN_BITS + KEY_BITS + MODE_BITS;

    logic [NUM_MODES*NUM_MODES-1:0] compat;
    logic             fq_valid, fq_ready, eq_valid, eq_ready;
    logic [CMD_W-1:0] fq_data, eq_data;
    logic [STATUS_BITS-1:0] st;

    ltgq_front #(
        .NUM_MODES(NUM_MODES), .TXN_BITS(TXN_BITS), .KEY_BITS(KEY_BITS), .CMD_W(CMD_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .compat(compat), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[CMD_W-1:0]), .q_valid(fq_valid), .q_ready(fq_ready),
        .q_data(fq_data)
    );

    ltgq_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .wr_data(fq_data), .rd_valid(eq_valid), .rd_ready(eq_ready), .rd_data(eq_data)
    );

    ltgq_engine #(
        .RESOURCE_SLOTS(RESOURCE_SLOTS), .OWNED_DEPTH(OWNED_DEPTH),
        .PENDING_DEPTH(PENDING_DEPTH), .NUM_MODES(NUM_MODES),
        .TXN_BITS(TXN_BITS), .KEY_BITS(KEY_BITS)
    ) u_engine (
        .clk(clk), .rst_n(rst_n), .compat(compat),
        .cmd_valid(eq_valid), .cmd_ready(eq_ready),
        .cmd_op(eq_data[0]),
        .cmd_txn(eq_data[TXN_BITS:1]),
        .cmd_key(eq_data[TXN_BITS+KEY_BITS:TXN_BITS+1]),
        .cmd_mode(eq_data[CMD_W-1:CMD_W-MODE_BITS]),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_status(st)
    );

    assign m_tdata = {5'd0, st};
endmodule
`default_nettype wire

// ===== rtl/ltgq_checker.sv =====
// port-level checks for the lock table, bound to the top level
`default_nettype none
module ltgq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("pad bits set");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");
endmodule

bind lock_table_grant_queue ltgq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
